// File: sv/iba_pkg.sv
// Shared types and constants for the batch admission block.
// No dependencies; imported by every module of the block but iba_fifo.
package iba_pkg;

	localparam int unsigned QDEPTH = 4;

	localparam logic [3:0] OC_SCHEDULED   = 4'd0;
	localparam logic [3:0] OC_LIMIT       = 4'd1;
	localparam logic [3:0] OC_IGNORED     = 4'd2;
	localparam logic [3:0] OC_RANGE       = 4'd3;
	localparam logic [3:0] OC_ORDER       = 4'd4;
	localparam logic [3:0] OC_NOT_READY   = 4'd5;
	localparam logic [3:0] OC_MODEL       = 4'd6;
	localparam logic [3:0] OC_PREFILL_OUT = 4'd7;
	localparam logic [3:0] OC_DECODE_NONE = 4'd8;
	localparam logic [3:0] OC_POS_OVF     = 4'd9;
	localparam logic [3:0] OC_TOKEN_OVF   = 4'd10;

	localparam logic [1:0] ST_PREFILL = 2'd0;
	localparam logic [1:0] ST_DECODE  = 2'd1;

	localparam logic [1:0] PH_RUNNING = 2'd0;
	localparam logic [1:0] PH_STOPPED = 2'd1;
	localparam logic [1:0] PH_FAILED  = 2'd2;
	localparam logic [1:0] PH_CLOSED  = 2'd3;

	localparam logic [1:0] REG_REQUEST_COUNT = 2'd0;
	localparam logic [1:0] REG_MAX_SEQUENCES = 2'd1;
	localparam logic [1:0] REG_MAX_TOKENS    = 2'd2;
	localparam logic [1:0] REG_PLAN_MODEL    = 2'd3;

	// classified request, front to back
	typedef struct packed {
		logic        first;
		logic        last;
		logic        range_err;
		logic [3:0]  check_code;
		logic        is_decode;
		logic [31:0] cost;
		logic [31:0] input_begin;
		logic [31:0] input_end;
		logic [31:0] out_position;
		logic [31:0] index;
		logic [31:0] request_id;
		logic [31:0] sequence_id;
		logic [31:0] epoch;
		logic [31:0] reservation_id;
	} item_t;

	// result word, back to output queue
	typedef struct packed {
		logic [3:0]  outcome;
		logic        is_decode;
		logic [31:0] input_begin;
		logic [31:0] input_end;
		logic [31:0] out_position;
		logic [31:0] out_request;
		logic [31:0] out_sequence;
		logic [31:0] out_epoch;
		logic [31:0] out_reservation;
		logic [6:0]  sequence_total;
		logic [31:0] token_total;
		logic        plan_done;
	} result_t;

endpackage

// File: sv/iba_fifo.sv
// Small register queue with count-based full and empty flags.
// Generic; no package dependency.
module iba_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/iba_front.sv
// Front end: per-request checks that need no plan state, and work ranges.
// Depends on iba_pkg.
module iba_front (
	input  logic               first,
	input  logic [31:0]        request_index,
	input  logic [1:0]         request_state,
	input  logic               has_reservation,
	input  logic [15:0]        model_id,
	input  logic [31:0]        prompt_len,
	input  logic [31:0]        committed_outputs,
	input  logic [31:0]        request_id,
	input  logic [31:0]        sequence_id,
	input  logic [31:0]        epoch,
	input  logic [31:0]        reservation_id,
	input  logic               last,
	input  logic [31:0]        request_count,
	input  logic [15:0]        plan_model,
	output iba_pkg::item_t     item
);
	import iba_pkg::*;

	logic [32:0] dec_end;
	logic        dec;

	assign dec     = (request_state == ST_DECODE);
	assign dec_end = {1'b0, prompt_len} + {1'b0, committed_outputs};

	always_comb begin
		item                 = '0;
		item.first           = first;
		item.last            = last;
		item.range_err       = (request_index >= request_count);
		item.index           = request_index;
		item.request_id      = request_id;
		item.sequence_id     = sequence_id;
		item.epoch           = epoch;
		item.reservation_id  = reservation_id;
		item.is_decode       = dec;
		if (dec) begin
			item.cost         = 32'd1;
			item.input_end    = dec_end[31:0];
			item.input_begin  = dec_end[31:0] - 32'd1;
			item.out_position = committed_outputs;
		end else begin
			item.cost         = prompt_len;
			item.input_end    = prompt_len;
			item.input_begin  = '0;
			item.out_position = '0;
		end
		if ((request_state != ST_PREFILL && !dec) || !has_reservation) begin
			item.check_code = OC_NOT_READY;
		end else if (model_id != plan_model) begin
			item.check_code = OC_MODEL;
		end else if (!dec && committed_outputs != '0) begin
			item.check_code = OC_PREFILL_OUT;
		end else if (dec && committed_outputs == '0) begin
			item.check_code = OC_DECODE_NONE;
		end else if (dec && dec_end[32]) begin
			item.check_code = OC_POS_OVF;
		end else begin
			item.check_code = OC_SCHEDULED;
		end
	end

endmodule

// File: sv/iba_back.sv
// Back end: plan state, order check, sequence and token limits, totals.
// Depends on iba_pkg.
module iba_back #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [6:0]         max_sequences,
	input  logic [31:0]        max_tokens,
	input  logic               item_valid,
	input  iba_pkg::item_t     item,
	output logic               item_pop,
	input  logic               res_full,
	output logic               res_push,
	output iba_pkg::result_t   res
);
	import iba_pkg::*;

	logic [31:0] used_q;
	logic [6:0]  count_q;
	logic [31:0] prior_q;
	logic        seen_q;
	logic [1:0]  phase_q;

	logic [31:0] used_c;
	logic [6:0]  count_c;
	logic [31:0] prior_c;
	logic        seen_c;
	logic [1:0]  phase_c;
	logic [31:0] used_n;
	logic [6:0]  count_n;
	logic [31:0] prior_n;
	logic        seen_n;
	logic [1:0]  phase_n;
	logic [6:0]  limit;
	logic [32:0] next_tok;
	logic [3:0]  oc;
	logic        fire;

	assign fire     = item_valid && !res_full;
	assign item_pop = fire;
	assign res_push = fire;

	always_comb begin
		if (32'(MAX_ENTRIES) < 32'(max_sequences)) begin
			limit = 7'(MAX_ENTRIES);
		end else begin
			limit = max_sequences;
		end
	end

	always_comb begin
		if (item.first) begin
			used_c  = '0;
			count_c = '0;
			prior_c = '0;
			seen_c  = 1'b0;
			phase_c = PH_RUNNING;
		end else begin
			used_c  = used_q;
			count_c = count_q;
			prior_c = prior_q;
			seen_c  = seen_q;
			phase_c = phase_q;
		end
		next_tok = {1'b0, used_c} + {1'b0, item.cost};
		used_n   = used_c;
		count_n  = count_c;
		prior_n  = prior_c;
		seen_n   = seen_c;
		phase_n  = phase_c;
		if (phase_c != PH_RUNNING) begin
			oc = OC_IGNORED;
		end else if (item.range_err) begin
			oc      = OC_RANGE;
			phase_n = PH_FAILED;
		end else if (seen_c && item.index <= prior_c) begin
			oc      = OC_ORDER;
			phase_n = PH_FAILED;
		end else begin
			seen_n  = 1'b1;
			prior_n = item.index;
			if (item.check_code != OC_SCHEDULED) begin
				oc      = item.check_code;
				phase_n = PH_FAILED;
			end else if (count_c >= limit) begin
				oc      = OC_LIMIT;
				phase_n = PH_STOPPED;
			end else if (next_tok[32]) begin
				oc      = OC_TOKEN_OVF;
				phase_n = PH_FAILED;
			end else if (next_tok[31:0] > max_tokens) begin
				oc      = OC_LIMIT;
				phase_n = PH_STOPPED;
			end else begin
				oc      = OC_SCHEDULED;
				count_n = count_c + 7'd1;
				used_n  = next_tok[31:0];
			end
		end
		if (item.last) begin
			phase_n = PH_CLOSED;
		end
	end

	always_comb begin
		res                = '0;
		res.outcome        = oc;
		res.sequence_total = count_n;
		res.token_total    = used_n;
		res.plan_done      = item.last;
		if (oc == OC_SCHEDULED) begin
			res.is_decode       = item.is_decode;
			res.input_begin     = item.input_begin;
			res.input_end       = item.input_end;
			res.out_position    = item.out_position;
			res.out_request     = item.request_id;
			res.out_sequence    = item.sequence_id;
			res.out_epoch       = item.epoch;
			res.out_reservation = item.reservation_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
			prior_q <= '0;
			seen_q  <= 1'b0;
			phase_q <= PH_RUNNING;
		end else if (fire) begin
			used_q  <= used_n;
			count_q <= count_n;
			prior_q <= prior_n;
			seen_q  <= seen_n;
			phase_q <= phase_n;
		end
	end

endmodule

// File: sv/inference_batch_admission.sv
// Inference batch admission: builds one step plan from selected requests, one
// result word per request word. Throughput is one word per clock in both
// directions while neither queue is full and results are popped. A word is
// classified by the front end as it is accepted into a 4-entry queue, then taken
// by the back end (plan state, order, limits and running totals, one 33-bit add
// and compare) into a 4-entry result queue, whose head drives the result ports.
// The back end's plan state update is the feedback loop through its registers
// that bounds the rate. Registers are written through cfg_wen/cfg_index/cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Depends on iba_pkg, iba_fifo, iba_front and iba_back.
module inference_batch_admission #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        first,
	input  logic [31:0] request_index,
	input  logic [1:0]  request_state,
	input  logic        has_reservation,
	input  logic [15:0] model_id,
	input  logic [31:0] prompt_len,
	input  logic [31:0] committed_outputs,
	input  logic [31:0] request_id,
	input  logic [31:0] sequence_id,
	input  logic [31:0] epoch,
	input  logic [31:0] reservation_id,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  outcome,
	output logic        is_decode,
	output logic [31:0] input_begin,
	output logic [31:0] input_end,
	output logic [31:0] out_position,
	output logic [31:0] out_request,
	output logic [31:0] out_sequence,
	output logic [31:0] out_epoch,
	output logic [31:0] out_reservation,
	output logic [6:0]  sequence_total,
	output logic [31:0] token_total,
	output logic        plan_done
);
	import iba_pkg::*;

	logic [31:0] request_count_q;
	logic [6:0]  max_sequences_q;
	logic [31:0] max_tokens_q;
	logic [15:0] plan_model_q;

	item_t   front_item;
	item_t   mid_item;
	logic    mid_empty;
	logic    mid_pop;
	logic    res_full;
	logic    res_push;
	result_t back_res;
	result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_count_q <= '0;
			max_sequences_q <= 7'd64;
			max_tokens_q    <= 32'd4096;
			plan_model_q    <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_REQUEST_COUNT: request_count_q <= cfg_data;
				REG_MAX_SEQUENCES: max_sequences_q <= cfg_data[6:0];
				REG_MAX_TOKENS:    max_tokens_q    <= cfg_data;
				REG_PLAN_MODEL:    plan_model_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	iba_front u_front (
		.first             (first),
		.request_index     (request_index),
		.request_state     (request_state),
		.has_reservation   (has_reservation),
		.model_id          (model_id),
		.prompt_len        (prompt_len),
		.committed_outputs (committed_outputs),
		.request_id        (request_id),
		.sequence_id       (sequence_id),
		.epoch             (epoch),
		.reservation_id    (reservation_id),
		.last              (last),
		.request_count     (request_count_q),
		.plan_model        (plan_model_q),
		.item              (front_item)
	);

	iba_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QDEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_item),
		.full    (full),
		.pop     (mid_pop),
		.rd_data (mid_item),
		.empty   (mid_empty)
	);

	iba_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_sequences (max_sequences_q),
		.max_tokens    (max_tokens_q),
		.item_valid    (!mid_empty),
		.item          (mid_item),
		.item_pop      (mid_pop),
		.res_full      (res_full),
		.res_push      (res_push),
		.res           (back_res)
	);

	iba_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QDEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (back_res),
		.full    (res_full),
		.pop     (pop),
		.rd_data (out_res),
		.empty   (empty)
	);

	assign outcome         = out_res.outcome;
	assign is_decode       = out_res.is_decode;
	assign input_begin     = out_res.input_begin;
	assign input_end       = out_res.input_end;
	assign out_position    = out_res.out_position;
	assign out_request     = out_res.out_request;
	assign out_sequence    = out_res.out_sequence;
	assign out_epoch       = out_res.out_epoch;
	assign out_reservation = out_res.out_reservation;
	assign sequence_total  = out_res.sequence_total;
	assign token_total     = out_res.token_total;
	assign plan_done       = out_res.plan_done;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for inference_batch_admission: directed and random step plans checked
// word by word against an in-bench admission predictor. Needs iba_pkg and the RTL.
module testbench;
	import iba_pkg::*;

	localparam int unsigned MAX_ENTRIES = 64;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam logic [1:0] ST_OTHER = 2'd2;
	localparam logic [1:0] ST_RESERVED = 2'd3;

	typedef struct packed {
		logic        first;
		logic [31:0] request_index;
		logic [1:0]  request_state;
		logic        has_reservation;
		logic [15:0] model_id;
		logic [31:0] prompt_len;
		logic [31:0] committed_outputs;
		logic [31:0] request_id;
		logic [31:0] sequence_id;
		logic [31:0] epoch;
		logic [31:0] reservation_id;
		logic        last;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = REG_REQUEST_COUNT;
	logic [31:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	request_t    drv = '0;

	logic        full;
	logic        empty;
	logic [3:0]  outcome;
	logic        is_decode;
	logic [31:0] input_begin;
	logic [31:0] input_end;
	logic [31:0] out_position;
	logic [31:0] out_request;
	logic [31:0] out_sequence;
	logic [31:0] out_epoch;
	logic [31:0] out_reservation;
	logic [6:0]  sequence_total;
	logic [31:0] token_total;
	logic        plan_done;
	result_t     seen_word;

	assign seen_word = {outcome, is_decode, input_begin, input_end, out_position,
		out_request, out_sequence, out_epoch, out_reservation, sequence_total,
		token_total, plan_done};

	// register copies
	logic [31:0] rc_reg = 32'd0;
	logic [6:0]  seq_reg = 7'd64;
	logic [31:0] tok_reg = 32'd4096;
	logic [15:0] model_reg = 16'd0;

	// plan state
	logic [31:0] used_tok = '0;
	logic [6:0]  admitted = '0;
	logic [31:0] prev_index = '0;
	logic        index_seen = 1'b0;
	logic [1:0]  plan_phase = PH_RUNNING;

	request_t    request_backlog[$];
	result_t     admission_q[$];
	int unsigned queued_words = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned pop_pct = 100;
	int unsigned pop_span = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	inference_batch_admission #(.MAX_ENTRIES(MAX_ENTRIES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.first(drv.first),
		.request_index(drv.request_index),
		.request_state(drv.request_state),
		.has_reservation(drv.has_reservation),
		.model_id(drv.model_id),
		.prompt_len(drv.prompt_len),
		.committed_outputs(drv.committed_outputs),
		.request_id(drv.request_id),
		.sequence_id(drv.sequence_id),
		.epoch(drv.epoch),
		.reservation_id(drv.reservation_id),
		.last(drv.last),
		.empty(empty),
		.pop(pop),
		.outcome(outcome),
		.is_decode(is_decode),
		.input_begin(input_begin),
		.input_end(input_end),
		.out_position(out_position),
		.out_request(out_request),
		.out_sequence(out_sequence),
		.out_epoch(out_epoch),
		.out_reservation(out_reservation),
		.sequence_total(sequence_total),
		.token_total(token_total),
		.plan_done(plan_done)
	);

	initial forever #5 clk = ~clk;

	function automatic result_t predict_admission(request_t r);
		result_t     res;
		logic [3:0]  oc;
		logic [32:0] sum;
		logic [31:0] cost;
		logic [31:0] pos_lo;
		logic [31:0] pos_hi;
		logic [31:0] opos;
		logic        dec;
		int unsigned seq_cap;
		res = '0;
		cost = '0;
		pos_lo = '0;
		pos_hi = '0;
		opos = '0;
		dec = 1'b0;
		if (r.first) begin
			used_tok = '0;
			admitted = '0;
			prev_index = '0;
			index_seen = 1'b0;
			plan_phase = PH_RUNNING;
		end
		if (plan_phase != PH_RUNNING) begin
			oc = OC_IGNORED;
		end else if (r.request_index >= rc_reg) begin
			oc = OC_RANGE;
		end else if (index_seen && r.request_index <= prev_index) begin
			oc = OC_ORDER;
		end else begin
			index_seen = 1'b1;
			prev_index = r.request_index;
			oc = OC_SCHEDULED;
			dec = (r.request_state == ST_DECODE);
			if ((r.request_state != ST_PREFILL && !dec) || !r.has_reservation) begin
				oc = OC_NOT_READY;
			end else if (r.model_id != model_reg) begin
				oc = OC_MODEL;
			end else if (!dec) begin
				if (r.committed_outputs != 0) begin
					oc = OC_PREFILL_OUT;
				end else begin
					cost = r.prompt_len;
					pos_hi = r.prompt_len;
				end
			end else if (r.committed_outputs == 0) begin
				oc = OC_DECODE_NONE;
			end else begin
				sum = {1'b0, r.prompt_len} + {1'b0, r.committed_outputs};
				if (sum[32]) begin
					oc = OC_POS_OVF;
				end else begin
					pos_hi = sum[31:0];
					pos_lo = pos_hi - 32'd1;
					cost = 32'd1;
					opos = r.committed_outputs;
				end
			end
			if (oc == OC_SCHEDULED) begin
				seq_cap = (seq_reg < MAX_ENTRIES) ? seq_reg : MAX_ENTRIES;
				sum = {1'b0, used_tok} + {1'b0, cost};
				if (admitted >= seq_cap) begin
					oc = OC_LIMIT;
				end else if (sum[32]) begin
					oc = OC_TOKEN_OVF;
				end else if (sum[31:0] > tok_reg) begin
					oc = OC_LIMIT;
				end else begin
					admitted = admitted + 7'd1;
					used_tok = sum[31:0];
					res.is_decode = dec;
					res.input_begin = pos_lo;
					res.input_end = pos_hi;
					res.out_position = opos;
					res.out_request = r.request_id;
					res.out_sequence = r.sequence_id;
					res.out_epoch = r.epoch;
					res.out_reservation = r.reservation_id;
				end
			end
		end
		if (oc == OC_LIMIT)
			plan_phase = PH_STOPPED;
		else if (oc >= OC_RANGE)
			plan_phase = PH_FAILED;
		if (r.last)
			plan_phase = PH_CLOSED;
		res.outcome = oc;
		res.sequence_total = admitted;
		res.token_total = used_tok;
		res.plan_done = r.last;
		return res;
	endfunction

	function automatic void add_word(input logic fst, input logic lst,
			input logic [31:0] idx, input logic [1:0] st, input logic resv,
			input logic [15:0] model, input logic [31:0] prompt,
			input logic [31:0] committed);
		request_t w;
		w.first = fst;
		w.last = lst;
		w.request_index = idx;
		w.request_state = st;
		w.has_reservation = resv;
		w.model_id = model;
		w.prompt_len = prompt;
		w.committed_outputs = committed;
		w.request_id = $urandom;
		w.sequence_id = $urandom;
		w.epoch = $urandom;
		w.reservation_id = $urandom;
		request_backlog.insert(request_backlog.size(), w);
		queued_words++;
	endfunction

	// well-formed plan with random content; faults injected when noisy
	function automatic void add_plan(input int unsigned n, input logic noisy);
		logic [31:0] idx;
		logic [31:0] prompt;
		logic [31:0] committed;
		logic [1:0]  st;
		logic [15:0] model;
		logic        resv;
		logic        close;
		close = ($urandom_range(4) != 0);
		idx = (rc_reg > 4 * n) ? $urandom % (rc_reg - 4 * n) : 32'd0;
		for (int unsigned i = 0; i < n; i++) begin
			st = $urandom_range(1) ? ST_DECODE : ST_PREFILL;
			resv = 1'b1;
			model = model_reg;
			prompt = (noisy && $urandom_range(15) == 0) ? $urandom : $urandom_range(300);
			committed = (st == ST_DECODE) ? $urandom_range(1, 500) : 32'd0;
			if (noisy && $urandom_range(11) == 0) begin
				case ($urandom_range(7))
					0: st = $urandom_range(1) ? ST_OTHER : ST_RESERVED;
					1: resv = 1'b0;
					2: model = model ^ 16'($urandom_range(1, 16'hFFFF));
					3: idx = idx - $urandom_range(2);
					4: idx = rc_reg + $urandom_range(3);
					5: committed = (st == ST_DECODE) ? 32'd0 : $urandom_range(1, 9);
					6: begin
						st = ST_DECODE;
						prompt = 32'hFFFF_FFFF - $urandom_range(3);
						committed = $urandom_range(1, 8);
					end
					default: prompt = $urandom;
				endcase
			end
			add_word(i == 0, close && i == n - 1, idx, st, resv, model, prompt, committed);
			idx = idx + $urandom_range(1, 3);
		end
	endfunction

	task automatic set_plan_regs(input logic [31:0] rc, input logic [6:0] ms,
			input logic [31:0] mt, input logic [15:0] pm);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= REG_REQUEST_COUNT;
		cfg_data <= rc;
		@(posedge clk);
		cfg_index <= REG_MAX_SEQUENCES;
		cfg_data <= {25'd0, ms};
		@(posedge clk);
		cfg_index <= REG_MAX_TOKENS;
		cfg_data <= mt;
		@(posedge clk);
		cfg_index <= REG_PLAN_MODEL;
		cfg_data <= {16'd0, pm};
		@(posedge clk);
		cfg_wen <= 1'b0;
		rc_reg = rc;
		seq_reg = ms;
		tok_reg = mt;
		model_reg = pm;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || push || admission_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic show_word(input string tag, input result_t w);
		$display("  %s oc=%0d dec=%0b in=%h:%h opos=%h", tag, w.outcome, w.is_decode,
			w.input_begin, w.input_end, w.out_position);
		$display("  %s ids=%h %h %h %h seq=%0d tok=%h done=%0b", tag, w.out_request,
			w.out_sequence, w.out_epoch, w.out_reservation, w.sequence_total,
			w.token_total, w.plan_done);
	endtask

	// sender: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				admission_q.insert(admission_q.size(), predict_admission(drv));
			if (!push || !full) begin
				if (gap_left != 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					drv <= request_backlog.pop_front();
					push <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(8) == 0) ? $urandom_range(30, 60)
							: $urandom_range(1, 16);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes per segment
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (admission_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result word with nothing pending", $realtime);
						show_word("got", seen_word);
					end
				end else begin
					want = admission_q.pop_front();
					if (seen_word !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result word mismatch", $realtime);
							show_word("exp", want);
							show_word("got", seen_word);
						end
					end
				end
			end
			if (pop_span == 0) begin
				pop_span = $urandom_range(1, 40);
				case ($urandom_range(3))
					0: pop_pct = 100;
					1: pop_pct = 70;
					2: pop_pct = 30;
					default: pop_pct = 5;
				endcase
			end else begin
				pop_span--;
			end
			pop <= ($urandom_range(99) < pop_pct);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] rc;
		logic [31:0] mt;
		logic [6:0]  ms;
		logic [15:0] pm;
		int unsigned stop_at;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_plan_regs(32'd1000, 7'd64, 32'd4096, 16'h1234);
		add_word(0, 0, 32'd0, ST_PREFILL, 1, 16'h1234, 32'd5, 32'd0);
		add_word(0, 0, 32'd3, ST_DECODE, 1, 16'h1234, 32'd10, 32'd1);
		add_word(0, 0, 32'd3, ST_PREFILL, 1, 16'h1234, 32'd1, 32'd0);
		add_word(0, 1, 32'd5, ST_PREFILL, 1, 16'h1234, 32'd1, 32'd0);
		add_word(0, 0, 32'd6, ST_PREFILL, 1, 16'h1234, 32'd1, 32'd0);
		add_word(1, 0, 32'd1000, ST_PREFILL, 1, 16'h1234, 32'd1, 32'd0);
		add_word(1, 0, 32'd999, ST_OTHER, 1, 16'h1234, 32'd1, 32'd0);
		add_word(1, 1, 32'd7, ST_RESERVED, 1, 16'h1234, 32'd1, 32'd0);
		add_word(1, 0, 32'd7, ST_DECODE, 0, 16'h1234, 32'd1, 32'd1);
		add_word(1, 0, 32'd8, ST_PREFILL, 1, 16'hFFFF, 32'd1, 32'd0);
		add_word(1, 0, 32'd9, ST_PREFILL, 1, 16'h1234, 32'd4, 32'hFFFF_FFFF);
		add_word(1, 0, 32'd9, ST_DECODE, 1, 16'h1234, 32'd4, 32'd0);
		add_word(1, 0, 32'd0, ST_DECODE, 1, 16'h1234, 32'hFFFF_FFFE, 32'd1);
		add_word(0, 0, 32'd999, ST_DECODE, 1, 16'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(1, 0, 32'd10, ST_PREFILL, 1, 16'h1234, 32'd4096, 32'd0);
		add_word(0, 0, 32'd11, ST_DECODE, 1, 16'h1234, 32'd0, 32'd1);
		add_word(0, 1, 32'd12, ST_PREFILL, 1, 16'h1234, 32'd1, 32'd0);
		add_word(1, 1, 32'd2, ST_PREFILL, 1, 16'h1234, 32'd4097, 32'd0);
		add_word(1, 0, 32'd0, ST_PREFILL, 1, 16'h1234, 32'd0, 32'd0);
		wait_idle();

		set_plan_regs(32'hFFFF_FFFF, 7'd2, 32'hFFFF_FFFF, 16'hFFFF);
		add_word(1, 0, 32'd0, ST_PREFILL, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
		add_word(0, 0, 32'hFFFF_FFFE, ST_DECODE, 1, 16'hFFFF, 32'd7, 32'd3);
		add_word(1, 0, 32'hFFFF_FFFF, ST_PREFILL, 1, 16'hFFFF, 32'd1, 32'd0);
		add_word(1, 0, 32'd1, ST_PREFILL, 1, 16'hFFFF, 32'd2, 32'd0);
		add_word(0, 0, 32'd2, ST_DECODE, 1, 16'hFFFF, 32'd2, 32'd5);
		add_word(0, 1, 32'd3, ST_PREFILL, 1, 16'hFFFF, 32'd2, 32'd0);
		wait_idle();

		set_plan_regs(32'd0, 7'd0, 32'd0, 16'd0);
		add_word(1, 1, 32'd0, ST_PREFILL, 1, 16'd0, 32'd0, 32'd0);
		wait_idle();
		set_plan_regs(32'd50, 7'd0, 32'd0, 16'd0);
		add_word(1, 1, 32'd0, ST_PREFILL, 1, 16'd0, 32'd0, 32'd0);
		wait_idle();

		// one long plan runs into the entry capacity
		set_plan_regs(32'hFFFF_FFFF, 7'd127, 32'hFFFF_FFFF, 16'($urandom));
		add_plan(70, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(3))
				0: rc = $urandom_range(16, 64);
				1: rc = $urandom_range(200, 5000);
				2: rc = 32'hFFFF_FFFF;
				default: rc = $urandom;
			endcase
			case ($urandom_range(9))
				0: ms = 7'd0;
				1, 2: ms = 7'($urandom_range(1, 8));
				3, 4: ms = 7'd64;
				5: ms = 7'($urandom_range(65, 127));
				default: ms = 7'($urandom_range(9, 63));
			endcase
			case ($urandom_range(4))
				0: mt = $urandom_range(50);
				1: mt = $urandom_range(500, 5000);
				2: mt = 32'd4096;
				3: mt = 32'hFFFF_FFFF;
				default: mt = $urandom;
			endcase
			case ($urandom_range(2))
				0: pm = 16'd0;
				1: pm = 16'hFFFF;
				default: pm = 16'($urandom);
			endcase
			set_plan_regs(rc, ms, mt, pm);
			stop_at = queued_words + 82;
			while (queued_words < stop_at) begin
				if ($urandom_range(9) == 0)
					add_word(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
						2'($urandom_range(3)), 1'($urandom_range(1)), 16'($urandom),
						$urandom, $urandom);
				else
					add_plan($urandom_range(1, 12), 1'b1);
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: inference_batch_admission.f
sv/iba_pkg.sv
sv/iba_fifo.sv
sv/iba_front.sv
sv/iba_back.sv
sv/inference_batch_admission.sv
tb/testbench.sv
